// ===== sv/deq_pkg.sv =====
// Package for the double-ended queue: sizes, operation codes, status codes and the
// structs passed between the queue control and the top level. No dependencies.
package deq_pkg;

	// Ring store geometry. DEPTH is a power of two so that slot arithmetic wraps.
	localparam int DEPTH      = 256;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int OP_W       = 3;
	localparam int POS_W      = 8;
	localparam int ST_W       = 2;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_AT    = 3'd4;

	// Status codes.
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

	// Access issued to the ring store for one item.
	typedef struct packed {
		logic              wr;
		logic              rd;
		logic [ADDR_W-1:0] addr;
	} mem_req_t;

	// Result fields known at the time the item is accepted.
	typedef struct packed {
		logic              rd;
		logic [ST_W-1:0]   status;
		logic [CNT_W-1:0]  occ;
	} resp_t;

endpackage

// ===== sv/deq_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One access per cycle: write, or read with the data registered.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// ===== sv/deq_ctrl.sv =====
// Queue control: front pointer and element count, error checks and the slot address
// for each item. Depends on deq_pkg.
module deq_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [deq_pkg::OP_W-1:0]    opcode,
	input  logic [deq_pkg::POS_W-1:0]   position,
	output deq_pkg::mem_req_t           mem_req,
	output deq_pkg::resp_t              resp
);
	import deq_pkg::*;

	logic [ADDR_W-1:0] front_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] front_nxt;
	logic [CNT_W-1:0]  count_nxt;
	logic              full;
	logic              empty;
	logic [ADDR_W-1:0] cnt_lo;
	logic [CNT_W-1:0]  pos_ext;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign cnt_lo  = count_q[ADDR_W-1:0];
	assign pos_ext = CNT_W'(position);

	// Decode the operation: slot address, store access and next pointer state.
	always_comb begin
		front_nxt    = front_q;
		count_nxt    = count_q;
		mem_req.wr   = 1'b0;
		mem_req.rd   = 1'b0;
		mem_req.addr = front_q;
		resp.rd      = 1'b0;
		resp.status  = ST_OK;
		unique case (opcode)
			OP_PUSH_BACK: begin
				mem_req.addr = front_q + cnt_lo;
				if (full) begin
					resp.status = ST_FULL;
				end else begin
					mem_req.wr = 1'b1;
					count_nxt  = count_q + 1'b1;
				end
			end
			OP_PUSH_FRONT: begin
				mem_req.addr = front_q - 1'b1;
				if (full) begin
					resp.status = ST_FULL;
				end else begin
					mem_req.wr = 1'b1;
					front_nxt  = front_q - 1'b1;
					count_nxt  = count_q + 1'b1;
				end
			end
			OP_POP_BACK: begin
				mem_req.addr = front_q + cnt_lo - 1'b1;
				if (empty) begin
					resp.status = ST_EMPTY;
				end else begin
					mem_req.rd = 1'b1;
					resp.rd    = 1'b1;
					count_nxt  = count_q - 1'b1;
				end
			end
			OP_POP_FRONT: begin
				mem_req.addr = front_q;
				if (empty) begin
					resp.status = ST_EMPTY;
				end else begin
					mem_req.rd = 1'b1;
					resp.rd    = 1'b1;
					front_nxt  = front_q + 1'b1;
					count_nxt  = count_q - 1'b1;
				end
			end
			OP_READ_AT: begin
				mem_req.addr = front_q + ADDR_W'(position);
				if (pos_ext >= count_q) begin
					resp.status = ST_RANGE;
				end else begin
					mem_req.rd = 1'b1;
					resp.rd    = 1'b1;
				end
			end
			default: begin
			end
		endcase
		resp.occ = count_nxt;
	end

	// Pointer state advances at the edge that accepts the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
		end
	end

endmodule

// ===== sv/double_ended_queue_top.sv =====
// Bounded double-ended queue on a 256-entry ring store.
// The result strobe rises in the cycle after the item is accepted (store read).
// Throughput: one item per cycle; busy stays low, as pointer updates finish at accept.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset: arst_n clears front pointer, count and the strobe; store contents stay undefined.
// Depends on deq_pkg, deq_ctrl and deq_ram.
module double_ended_queue_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [deq_pkg::OP_W-1:0]         opcode,
	input  logic [deq_pkg::DATA_WIDTH-1:0]   value_in,
	input  logic [deq_pkg::POS_W-1:0]        position,
	output logic                             done,
	output logic [deq_pkg::DATA_WIDTH-1:0]   value_out,
	output logic [deq_pkg::ST_W-1:0]         status,
	output logic [deq_pkg::CNT_W-1:0]        occupancy
);
	import deq_pkg::*;

	logic                  accept;
	mem_req_t              mem_req;
	resp_t                 resp;
	logic [DATA_WIDTH-1:0] rdata;
	logic                  done_s1;
	logic                  rd_s1;
	logic [ST_W-1:0]       status_s1;
	logic [CNT_W-1:0]      occ_s1;

	// Every item completes in a single pass, so the block is always free.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.opcode   (opcode),
		.position (position),
		.mem_req  (mem_req),
		.resp     (resp)
	);

	deq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.en    (accept && (mem_req.wr || mem_req.rd)),
		.we    (mem_req.wr),
		.addr  (mem_req.addr),
		.wdata (value_in),
		.rdata (rdata)
	);

	// Result stage: strobe and the fields that travel alongside the store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= resp.rd;
			status_s1 <= resp.status;
			occ_s1    <= resp.occ;
		end
	end

	assign done      = done_s1;
	assign value_out = rd_s1 ? rdata : '0;
	assign status    = status_s1;
	assign occupancy = occ_s1;

`ifndef SYNTHESIS
	// A result follows only an accepted item.
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("result without an accepted item");

	// The count never exceeds the store depth.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (occupancy <= CNT_W'(DEPTH)))
		else $error("occupancy above depth");

	// A full report means the queue really is full.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (occupancy == CNT_W'(DEPTH)))
		else $error("full status with room left");

	// Errors return a zero word.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (value_out == '0))
		else $error("nonzero word on an error");
`endif

endmodule

// ===== tb/sv/tb_double_ended_queue_top.sv =====
// Self-checking testbench for double_ended_queue_top: directed and random queue operations,
// checked against an in-bench model of the ring store. Depends on deq_pkg and the RTL.
`timescale 1ns / 100ps

module tb_double_ended_queue_top;
	import deq_pkg::*;

	// Opcodes outside the defined set act as no-ops.
	localparam logic [OP_W-1:0] OP_NOP_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_NOP_LAST  = 3'd7;

	// The limit lies well above the length of the slowest run, leaving a wide margin.
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned RANDOM_ITEMS  = 1100;
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam int unsigned REPORT_MAX    = 10;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} gen_mode_t;

	typedef struct {
		logic [OP_W-1:0]       op;
		logic [DATA_WIDTH-1:0] value;
		logic [POS_W-1:0]      pos;
		bit                    drain_first;
	} deque_cmd_t;

	typedef struct {
		logic [DATA_WIDTH-1:0] value;
		logic [ST_W-1:0]       status;
		logic [CNT_W-1:0]      occ;
	} deque_resp_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic [OP_W-1:0]       opcode    = '0;
	logic [DATA_WIDTH-1:0] value_in  = '0;
	logic [POS_W-1:0]      position  = '0;
	logic                  busy;
	logic                  done;
	logic [DATA_WIDTH-1:0] value_out;
	logic [ST_W-1:0]       status;
	logic [CNT_W-1:0]      occupancy;

	// Model state of the ring.
	logic [DATA_WIDTH-1:0] deque_store [DEPTH];
	logic [ADDR_W-1:0]     deque_front = '0;
	logic [CNT_W-1:0]      deque_count = '0;

	deque_cmd_t  pending_cmds[$];
	deque_resp_t expected_results[$];
	deque_cmd_t  driven_cmd;

	int unsigned n_issued   = 0;
	int unsigned n_seen     = 0;
	int unsigned n_mismatch = 0;
	int unsigned cycle_count = 0;
	int unsigned gap_left   = 0;
	int unsigned burst_left = 0;
	int unsigned roll;
	int unsigned gen_count  = 0;
	bit          next_start;
	bit          drained;

	double_ended_queue_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.value_in  (value_in),
		.position  (position),
		.done      (done),
		.value_out (value_out),
		.status    (status),
		.occupancy (occupancy)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Applies one operation to the model ring and returns the result it yields.
	function automatic deque_resp_t apply_deque_op(deque_cmd_t cmd);
		deque_resp_t       resp;
		logic [ADDR_W-1:0] slot;
		resp.value  = '0;
		resp.status = ST_OK;
		case (cmd.op)
			OP_PUSH_BACK: begin
				if (deque_count == CNT_W'(DEPTH)) begin
					resp.status = ST_FULL;
				end else begin
					slot = deque_front + deque_count[ADDR_W-1:0];
					deque_store[slot] = cmd.value;
					deque_count++;
				end
			end
			OP_PUSH_FRONT: begin
				if (deque_count == CNT_W'(DEPTH)) begin
					resp.status = ST_FULL;
				end else begin
					deque_front--;
					deque_store[deque_front] = cmd.value;
					deque_count++;
				end
			end
			OP_POP_BACK: begin
				if (deque_count == 0) begin
					resp.status = ST_EMPTY;
				end else begin
					slot = deque_front + deque_count[ADDR_W-1:0] - 1'b1;
					resp.value = deque_store[slot];
					deque_count--;
				end
			end
			OP_POP_FRONT: begin
				if (deque_count == 0) begin
					resp.status = ST_EMPTY;
				end else begin
					resp.value = deque_store[deque_front];
					deque_front++;
					deque_count--;
				end
			end
			OP_READ_AT: begin
				if (CNT_W'(cmd.pos) >= deque_count) begin
					resp.status = ST_RANGE;
				end else begin
					slot = deque_front + cmd.pos;
					resp.value = deque_store[slot];
				end
			end
			default: begin
			end
		endcase
		resp.occ = deque_count;
		return resp;
	endfunction

	// Queues one item and tracks the element count so that reads can aim inside the range.
	function automatic void add_item(logic [OP_W-1:0] op, logic [DATA_WIDTH-1:0] value,
			logic [POS_W-1:0] pos, bit drain_first);
		deque_cmd_t cmd;
		cmd.op          = op;
		cmd.value       = value;
		cmd.pos         = pos;
		cmd.drain_first = drain_first;
		pending_cmds.push_back(cmd);
		if ((op == OP_PUSH_BACK || op == OP_PUSH_FRONT) && gen_count < DEPTH) begin
			gen_count++;
		end else if ((op == OP_POP_BACK || op == OP_POP_FRONT) && gen_count > 0) begin
			gen_count--;
		end
	endfunction

	// Driver: records accepted items, then presents the next one after its idle gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			opcode   <= '0;
			value_in <= '0;
			position <= '0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(apply_deque_op(driven_cmd));
				n_issued++;
			end
			drained = (n_issued == n_seen + done);
			if (!(start && busy)) begin
				next_start = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_cmds.size() != 0 &&
						(!pending_cmds[0].drain_first || drained)) begin
					driven_cmd = pending_cmds.pop_front();
					opcode   <= driven_cmd.op;
					value_in <= driven_cmd.value;
					position <= driven_cmd.pos;
					next_start = 1'b1;
					// Mostly short gaps, a few long ones, and bursts with none.
					roll = $urandom_range(0, 99);
					if (burst_left != 0) begin
						burst_left--;
						gap_left = 0;
					end else if (roll < 4) begin
						burst_left = $urandom_range(20, 60);
						gap_left = 0;
					end else if (roll < 50) begin
						gap_left = 0;
					end else if (roll < 90) begin
						gap_left = $urandom_range(1, 3);
					end else begin
						gap_left = $urandom_range(8, 40);
					end
				end
				start <= next_start;
			end
		end
	end

	// Monitor: each strobed result is compared with the oldest expected one.
	always @(posedge clk or negedge arst_n) begin
		deque_resp_t want;
		if (!arst_n) begin
			n_seen <= 0;
		end else if (done) begin
			n_seen <= n_seen + 1;
			if (expected_results.size() == 0) begin
				if (n_mismatch < REPORT_MAX) begin
					$display("ERROR: unexpected result value=%h status=%0d occupancy=%0d",
						value_out, status, occupancy);
				end
				n_mismatch++;
			end else begin
				want = expected_results.pop_front();
				if (value_out !== want.value || status !== want.status ||
						occupancy !== want.occ) begin
					if (n_mismatch < REPORT_MAX) begin
						$display("ERROR: result %0d expected value=%h status=%0d occupancy=%0d",
							n_seen, want.value, want.status, want.occ);
						$display("       actual value=%h status=%0d occupancy=%0d",
							value_out, status, occupancy);
					end
					n_mismatch++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Stimulus build, reset and end of test.
	initial begin
		gen_mode_t   mode;
		int unsigned phase;
		int unsigned len;
		int unsigned n_rand;
		int unsigned pick;
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] pos;

		// Directed: empty pops and reads, value extremes, front pointer wrap, no-ops,
		// range edges, and reuse of the ring after emptying.
		add_item(OP_POP_BACK,   $urandom, POS_W'($urandom), 1'b0);
		add_item(OP_POP_FRONT,  $urandom, POS_W'($urandom), 1'b0);
		add_item(OP_READ_AT,    $urandom, 8'd0, 1'b0);
		add_item(OP_NOP_FIRST,  '1, '1, 1'b0);
		add_item(OP_PUSH_BACK,  32'h0000_0000, '0, 1'b0);
		add_item(OP_PUSH_BACK,  32'hFFFF_FFFF, '1, 1'b0);
		add_item(OP_PUSH_FRONT, 32'hA5A5_A5A5, '0, 1'b0);
		add_item(OP_PUSH_FRONT, 32'h5A5A_5A5A, '0, 1'b0);
		add_item(OP_READ_AT,    $urandom, 8'd0, 1'b0);
		add_item(OP_READ_AT,    $urandom, 8'd3, 1'b0);
		add_item(OP_READ_AT,    $urandom, 8'd4, 1'b0);
		add_item(OP_READ_AT,    $urandom, 8'd255, 1'b0);
		add_item(OP_NOP_FIRST + 3'd1, '1, '1, 1'b0);
		add_item(OP_NOP_LAST,   '0, '0, 1'b0);
		add_item(OP_POP_BACK,   $urandom, POS_W'($urandom), 1'b0);
		add_item(OP_POP_FRONT,  $urandom, POS_W'($urandom), 1'b0);
		add_item(OP_POP_FRONT,  $urandom, POS_W'($urandom), 1'b0);
		add_item(OP_POP_BACK,   $urandom, POS_W'($urandom), 1'b0);
		add_item(OP_POP_FRONT,  $urandom, POS_W'($urandom), 1'b0);
		add_item(OP_PUSH_BACK,  32'h1234_5678, '0, 1'b1);
		add_item(OP_READ_AT,    $urandom, 8'd0, 1'b0);
		add_item(OP_POP_FRONT,  $urandom, POS_W'($urandom), 1'b0);

		// Random phases: a full fill and a full drain first, then mixed lengths and modes.
		phase  = 0;
		n_rand = 0;
		while (n_rand < RANDOM_ITEMS) begin
			if (phase == 0) begin
				mode = MODE_FILL;
			end else if (phase == 1) begin
				mode = MODE_DRAIN;
			end else begin
				mode = gen_mode_t'($urandom_range(0, 2));
			end
			len = (phase < 2) ? 330 : $urandom_range(60, 200);
			if (len > RANDOM_ITEMS - n_rand) begin
				len = RANDOM_ITEMS - n_rand;
			end
			for (int unsigned k = 0; k < len; k++) begin
				pick = $urandom_range(0, 99);
				case (mode)
					MODE_FILL:  pick = (pick < 90) ? pick % 35 : 35 + pick % 65;
					MODE_DRAIN: pick = (pick < 90) ? 35 + pick % 30 : pick;
					default:    begin
					end
				endcase
				// 0..34 push, 35..64 pop, 65..94 read, 95..99 no-op.
				if (pick < 35) begin
					op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
				end else if (pick < 65) begin
					op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
				end else if (pick < 95) begin
					op = OP_READ_AT;
				end else begin
					op = OP_W'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
				end
				if (gen_count > 0 && $urandom_range(0, 9) < 7) begin
					pos = POS_W'($urandom_range(0, gen_count - 1));
				end else begin
					pos = POS_W'($urandom);
				end
				add_item(op, $urandom, pos,
					(k == 0 && $urandom_range(0, 1)) || $urandom_range(0, 149) == 0);
				n_rand++;
			end
			phase++;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the last item and its result, then watch for stray strobes.
		while (pending_cmds.size() != 0 || start || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (n_mismatch == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
